@@ rtl/bma_pkg.sv @@
`timescale 1ns / 1ps

package bma_pkg;

    // Operation codes carried on the op field.
    typedef enum logic [3:0] {
        OP_LEN      = 4'd0,
        OP_CLZ      = 4'd1,
        OP_CTZ      = 4'd2,
        OP_POPCOUNT = 4'd3,
        OP_ROTL     = 4'd4,
        OP_BITREV   = 4'd5,
        OP_BYTEREV  = 4'd6,
        OP_ADD      = 4'd7,
        OP_SUB      = 4'd8,
        OP_MUL      = 4'd9
    } op_t;

    // Field widths of the ports, fixed by the interface.
    localparam int PORT_W   = 64;
    localparam int OP_W     = 4;
    localparam int ROT_W    = 6;

    // Population count is done per byte lane of the 64-bit port word.
    localparam int LANES    = 8;
    localparam int POP_W    = 7;

    typedef logic [3:0] byte_cnt_t;
    typedef byte_cnt_t [LANES-1:0] byte_cnts_t;

endpackage

@@ rtl/bma_bitops.sv @@
`timescale 1ns / 1ps

module bma_bitops #(
    parameter int WORD_WIDTH = 64
) (
    input  bma_pkg::op_t                     op,
    input  logic [WORD_WIDTH-1:0]            x,
    input  logic [$clog2(WORD_WIDTH)-1:0]    k,
    output logic [WORD_WIDTH-1:0]            misc_word,
    output bma_pkg::byte_cnts_t              byte_cnts
);
    import bma_pkg::*;

    localparam int CW = $clog2(WORD_WIDTH + 1);

    logic [CW-1:0]           len;
    logic [CW-1:0]           ctz;
    logic [CW-1:0]           clz;
    logic [WORD_WIDTH-1:0]   bit_rev;
    logic [PORT_W-1:0]       ext;
    logic [PORT_W-1:0]       byte_swp;
    logic [2*WORD_WIDTH-1:0] dbl;

    always_comb begin
        len = '0;
        for (int i = 0; i < WORD_WIDTH; i++) begin
            if (x[i]) begin
                len = CW'(i + 1);
            end
        end
        clz = CW'(WORD_WIDTH) - len;

        // A zero word reports the full width as its trailing-zero count.
        ctz = CW'(WORD_WIDTH);
        for (int i = WORD_WIDTH - 1; i >= 0; i--) begin
            if (x[i]) begin
                ctz = CW'(i);
            end
        end

        for (int i = 0; i < WORD_WIDTH; i++) begin
            bit_rev[i] = x[WORD_WIDTH-1-i];
        end

        // Byte reversal works on the full port word; the top bits hold the answer.
        ext = PORT_W'(x);
        for (int b = 0; b < LANES; b++) begin
            byte_swp[8*b +: 8] = ext[8*(LANES-1-b) +: 8];
        end

        dbl = {x, x} << k;

        for (int b = 0; b < LANES; b++) begin
            byte_cnts[b] = 4'($countones(ext[8*b +: 8]));
        end

        case (op)
            OP_LEN:     misc_word = WORD_WIDTH'(len);
            OP_CLZ:     misc_word = WORD_WIDTH'(clz);
            OP_CTZ:     misc_word = WORD_WIDTH'(ctz);
            OP_ROTL:    misc_word = dbl[2*WORD_WIDTH-1 -: WORD_WIDTH];
            OP_BITREV:  misc_word = bit_rev;
            OP_BYTEREV: misc_word = byte_swp[PORT_W-1 -: WORD_WIDTH];
            default:    misc_word = '0;
        endcase
    end

endmodule

@@ rtl/bit_manipulation_alu_64.sv @@
`timescale 1ns / 1ps

// Channel   | Ports                                              | Direction
// ----------+----------------------------------------------------+----------
// input     | s_valid s_ready s_op s_x s_y s_carry_in            | in
//           | s_rotate_amount                                    |
// result    | m_valid m_ready m_result m_product_high m_carry_out | out
//
// One item is accepted per cycle while s_ready is high, and every item gives one result
// item. The edge that accepts an item loads it into the first of four register stages,
// and its result item leaves from the last. The stages are operand capture, the
// half-word partial products, the middle partial-product sum, and the final 128-bit
// product add that feeds the output register.
// Reset is synchronous and active low; it clears the valid bit of every stage.
// When m_ready is low the output holds; upstream stages keep filling their bubbles,
// and s_ready falls only once all four stages hold an item.

module bit_manipulation_alu_64 #(
    parameter int WORD_WIDTH = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bma_pkg::OP_W-1:0]    s_op,
    input  logic [bma_pkg::PORT_W-1:0]  s_x,
    input  logic [bma_pkg::PORT_W-1:0]  s_y,
    input  logic                        s_carry_in,
    input  logic [bma_pkg::ROT_W-1:0]   s_rotate_amount,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bma_pkg::PORT_W-1:0]  m_result,
    output logic [bma_pkg::PORT_W-1:0]  m_product_high,
    output logic                        m_carry_out
);
    import bma_pkg::*;

    localparam int W    = WORD_WIDTH;
    localparam int KW   = $clog2(W);
    // The multiplier splits each operand into a low and a high part.
    localparam int HALF = (W + 1) / 2;
    localparam int HIW  = W - HALF;

    // Stage enables: a stage loads when it is empty or its successor moves on.
    logic en1, en2, en3, en4;

    logic v1_reg, v2_reg, v3_reg, m_valid_reg;

    // Stage 1: captured operands.
    op_t            op1_reg, op1_next;
    logic [W-1:0]   x1_reg, x1_next;
    logic [W-1:0]   y1_reg, y1_next;
    logic           c1_reg;
    logic [KW-1:0]  k1_reg, k1_next;
    logic [ROT_W:0] k_work;

    // Stage 2: partial products, add or subtract, single-word operations.
    op_t                  op2_reg;
    logic [W:0]           arith2_reg, arith2_next;
    logic [W-1:0]         misc2_reg, misc2_next;
    byte_cnts_t           cnt2_reg, cnt2_next;
    logic [2*HALF-1:0]    pll2_reg, pll2_next;
    logic [W-1:0]         plh2_reg, plh2_next;
    logic [W-1:0]         phl2_reg, phl2_next;
    logic [2*HIW-1:0]     phh2_reg, phh2_next;

    // Stage 3: middle sum and finished population count.
    op_t                  op3_reg;
    logic [W:0]           arith3_reg;
    logic [W-1:0]         misc3_reg;
    logic [POP_W-1:0]     pop3_reg, pop3_next;
    logic [W:0]           mid3_reg, mid3_next;
    logic [2*HALF-1:0]    pll3_reg;
    logic [2*HIW-1:0]     phh3_reg;

    // Stage 4: output register.
    logic [2*W-1:0]       prod;
    logic [PORT_W-1:0]    result_reg, result_next;
    logic [PORT_W-1:0]    hi_reg, hi_next;
    logic                 co_reg, co_next;

    assign en4     = !m_valid_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    // Stage 1 logic: keep the low word bits and reduce the rotate distance modulo
    // the word width. The distance is below 64 and the width at least 8, so seven
    // conditional subtractions are enough.
    always_comb begin
        op1_next = op_t'(s_op);
        x1_next  = s_x[W-1:0];
        y1_next  = s_y[W-1:0];
        k_work   = {1'b0, s_rotate_amount};
        for (int i = 0; i < 7; i++) begin
            if (k_work >= (ROT_W+1)'(W)) begin
                k_work = k_work - (ROT_W+1)'(W);
            end
        end
        k1_next = k_work[KW-1:0];
    end

    // Stage 2 logic.
    bma_bitops #(
        .WORD_WIDTH (W)
    ) u_bitops (
        .op        (op1_reg),
        .x         (x1_reg),
        .k         (k1_reg),
        .misc_word (misc2_next),
        .byte_cnts (cnt2_next)
    );

    always_comb begin
        // The top bit is the carry for add and, in two's complement, the borrow
        // for subtract.
        if (op1_reg == OP_SUB) begin
            arith2_next = {1'b0, x1_reg} - {1'b0, y1_reg} - (W+1)'(c1_reg);
        end else begin
            arith2_next = {1'b0, x1_reg} + {1'b0, y1_reg} + (W+1)'(c1_reg);
        end
        pll2_next = (2*HALF)'(x1_reg[HALF-1:0]) * (2*HALF)'(y1_reg[HALF-1:0]);
        plh2_next = W'(x1_reg[HALF-1:0]) * W'(y1_reg[W-1:HALF]);
        phl2_next = W'(x1_reg[W-1:HALF]) * W'(y1_reg[HALF-1:0]);
        phh2_next = (2*HIW)'(x1_reg[W-1:HALF]) * (2*HIW)'(y1_reg[W-1:HALF]);
    end

    // Stage 3 logic.
    always_comb begin
        pop3_next = '0;
        for (int b = 0; b < LANES; b++) begin
            pop3_next = pop3_next + POP_W'(cnt2_reg[b]);
        end
        mid3_next = (W+1)'(plh2_reg) + (W+1)'(phl2_reg);
    end

    // Stage 4 logic: finish the product and pick the fields for the operation.
    always_comb begin
        prod        = {phh3_reg, pll3_reg} + ((2*W)'(mid3_reg) << HALF);
        result_next = '0;
        hi_next     = '0;
        co_next     = 1'b0;
        case (op3_reg)
            OP_LEN, OP_CLZ, OP_CTZ, OP_ROTL, OP_BITREV, OP_BYTEREV: begin
                result_next = PORT_W'(misc3_reg);
            end
            OP_POPCOUNT: begin
                result_next = PORT_W'(pop3_reg);
            end
            OP_ADD, OP_SUB: begin
                result_next = PORT_W'(arith3_reg[W-1:0]);
                co_next     = arith3_reg[W];
            end
            OP_MUL: begin
                result_next = PORT_W'(prod[W-1:0]);
                hi_next     = PORT_W'(prod[2*W-1:W]);
            end
            default: begin
                result_next = '0;
            end
        endcase
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                m_valid_reg <= v3_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (en1) begin
            op1_reg <= op1_next;
            x1_reg  <= x1_next;
            y1_reg  <= y1_next;
            c1_reg  <= s_carry_in;
            k1_reg  <= k1_next;
        end
        if (en2) begin
            op2_reg    <= op1_reg;
            arith2_reg <= arith2_next;
            misc2_reg  <= misc2_next;
            cnt2_reg   <= cnt2_next;
            pll2_reg   <= pll2_next;
            plh2_reg   <= plh2_next;
            phl2_reg   <= phl2_next;
            phh2_reg   <= phh2_next;
        end
        if (en3) begin
            op3_reg    <= op2_reg;
            arith3_reg <= arith2_reg;
            misc3_reg  <= misc2_reg;
            pop3_reg   <= pop3_next;
            mid3_reg   <= mid3_next;
            pll3_reg   <= pll2_reg;
            phh3_reg   <= phh2_reg;
        end
        if (en4) begin
            result_reg <= result_next;
            hi_reg     <= hi_next;
            co_reg     <= co_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result       = result_reg;
    assign m_product_high = hi_reg;
    assign m_carry_out    = co_reg;

endmodule

@@ rtl/bma_checker.sv @@
`timescale 1ns / 1ps

module bma_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [bma_pkg::PORT_W-1:0]  m_result,
    input logic [bma_pkg::PORT_W-1:0]  m_product_high,
    input logic                        m_carry_out
);
    import bma_pkg::*;

    // Items inside the block: accepted but not yet delivered.
    logic [2:0] occ_reg, occ_next;
    logic       in_fire, out_fire;

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;

    always_comb begin
        occ_next = occ_reg + 3'(in_fire) - 3'(out_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result)
            && $stable(m_product_high) && $stable(m_carry_out))
        else $error("result item changed while stalled");

    // No result appears without an item inside the block.
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> occ_reg != 3'd0)
        else $error("result item without an accepted item");

    // The four stages hold at most four items.
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= 3'd4)
        else $error("more items inside than pipeline stages");

    // Carry belongs to add and subtract, the high word to multiply.
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_carry_out |-> m_product_high == '0)
        else $error("carry and product high word both set");

    // Reset empties the output stage.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind bit_manipulation_alu_64 bma_checker u_bma_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result       (m_result),
    .m_product_high (m_product_high),
    .m_carry_out    (m_carry_out)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench for the 64-bit bit-manipulation and extended-arithmetic unit.
// An initial block fills a queue of operand items. A clocked driver presents them on
// the input channel, and a clocked monitor takes result items off the output channel.
// When an operand item is accepted, the driver works out its result with a local
// predictor and queues it. The monitor checks each result item against the oldest
// queued prediction, field by field.

module tb_top;

    import bma_pkg::*;

    // Opcodes above OP_MUL are unused. The unit must still return one all-zero result
    // for each of them.
    localparam logic [3:0] OP_UNUSED_LO = 4'd10;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_PCT     = 29;
    // Four pipeline stages, plus a few spare cycles, before the run is declared quiet.
    localparam int SETTLE_CYCLES = 12;
    // Each of about 475 items may see sender gaps and receiver stalls of a few cycles.
    // This limit is many times the slowest correct run.
    localparam int CYCLE_LIMIT  = 40000;
    // Both sides stop idling inside this window of cycles.
    localparam int BURST_START  = 250;
    localparam int BURST_END    = 420;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PORT_W-1:0] x;
        logic [PORT_W-1:0] y;
        logic              carry_in;
        logic [ROT_W-1:0]  rotate_amount;
        logic              settle_first;    // hold off until every result is back
    } operand_item_t;

    typedef struct packed {
        logic [PORT_W-1:0] result;
        logic [PORT_W-1:0] product_high;
        logic              carry_out;
    } alu_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;

    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op = '0;
    logic [PORT_W-1:0]   s_x = '0;
    logic [PORT_W-1:0]   s_y = '0;
    logic                s_carry_in = 1'b0;
    logic [ROT_W-1:0]    s_rotate_amount = '0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [PORT_W-1:0]   m_result;
    logic [PORT_W-1:0]   m_product_high;
    logic                m_carry_out;

    operand_item_t pending_operands[$];
    alu_result_t   awaited_results[$];
    operand_item_t in_flight;
    alu_result_t   oldest_result;
    int            error_count = 0;
    int            cycle_count = 0;
    logic          burst;

    bit_manipulation_alu_64 DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_x             (s_x),
        .s_y             (s_y),
        .s_carry_in      (s_carry_in),
        .s_rotate_amount (s_rotate_amount),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result        (m_result),
        .m_product_high  (m_product_high),
        .m_carry_out     (m_carry_out)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    assign burst = (cycle_count >= BURST_START) && (cycle_count < BURST_END);

    // The predictor works from the bit vectors directly. Length and zero counts use bit
    // loops, the population count $countones, rotates concatenation and reversals loops.
    // Add, subtract and multiply results come from arithmetic at the full output width, so
    // each carry, borrow or product high word is simply the top part of the wide value.
    function automatic alu_result_t predict_bit_op(input operand_item_t it);
        alu_result_t      r;
        logic [2*PORT_W-1:0] wide;
        logic [PORT_W:0]  sum;
        int               top;
        int               low;
        r    = '0;
        top  = 0;
        low  = PORT_W;
        for (int i = 0; i < PORT_W; i++) begin
            if (it.x[i]) begin
                top = i + 1;
            end
        end
        for (int i = PORT_W - 1; i >= 0; i--) begin
            if (it.x[i]) begin
                low = i;
            end
        end
        case (op_t'(it.op))
            OP_LEN:      r.result = PORT_W'(top);
            OP_CLZ:      r.result = PORT_W'(PORT_W - top);
            OP_CTZ:      r.result = PORT_W'(low);
            OP_POPCOUNT: r.result = PORT_W'($countones(it.x));
            OP_ROTL: begin
                // The upper half of the doubled word, shifted, is the left rotation.
                wide     = {it.x, it.x} << it.rotate_amount;
                r.result = wide[2*PORT_W-1:PORT_W];
            end
            OP_BITREV: begin
                for (int i = 0; i < PORT_W; i++) begin
                    r.result[i] = it.x[PORT_W-1-i];
                end
            end
            OP_BYTEREV: begin
                for (int b = 0; b < PORT_W / 8; b++) begin
                    r.result[8*b +: 8] = it.x[8*(PORT_W/8-1-b) +: 8];
                end
            end
            OP_ADD: begin
                sum         = {1'b0, it.x} + {1'b0, it.y} + {{PORT_W{1'b0}}, it.carry_in};
                r.result    = sum[PORT_W-1:0];
                r.carry_out = sum[PORT_W];
            end
            OP_SUB: begin
                // The wrapped 65-bit difference has its top bit set exactly when
                // x < y + borrow.
                sum         = {1'b0, it.x} - {1'b0, it.y} - {{PORT_W{1'b0}}, it.carry_in};
                r.result    = sum[PORT_W-1:0];
                r.carry_out = sum[PORT_W];
            end
            OP_MUL: begin
                wide           = {{PORT_W{1'b0}}, it.x} * {{PORT_W{1'b0}}, it.y};
                r.result       = wide[PORT_W-1:0];
                r.product_high = wide[2*PORT_W-1:PORT_W];
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // Operand shapes that reach the edges of the counting operations as well as sparse
    // and dense random words.
    function automatic logic [PORT_W-1:0] shaped_word();
        logic [PORT_W-1:0] w;
        int                k;
        w = {$urandom, $urandom};
        k = $urandom_range(PORT_W - 1);
        case ($urandom_range(7))
            0:       w = '0;
            1:       w = '1;
            2:       w = {{(PORT_W-1){1'b0}}, 1'b1} << k;
            3:       w = '1 >> k;
            4:       w = '1 << k;
            5:       w = w & {$urandom, $urandom} & {$urandom, $urandom};
            default: ;
        endcase
        return w;
    endfunction

    task automatic queue_operand(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] x,
                                 input logic [PORT_W-1:0] y, input logic c,
                                 input logic [ROT_W-1:0] rot, input logic settle);
        operand_item_t it;
        it.op            = op;
        it.x             = x;
        it.y             = y;
        it.carry_in      = c;
        it.rotate_amount = rot;
        it.settle_first  = settle;
        pending_operands.push_back(it);
    endtask

    // Driver. The item currently on the port is held until it is accepted. At the edge
    // where it is accepted, its prediction is queued and the next item, if any and not held
    // back, is put on the port. s_valid gets at most one nonblocking assignment per edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_results.push_back(predict_bit_op(in_flight));
            end
            if (!s_valid || s_ready) begin
                if (pending_operands.size() != 0
                        && !(pending_operands[0].settle_first && awaited_results.size() != 0)
                        && (burst || $urandom_range(99) >= IDLE_PCT)) begin
                    in_flight = pending_operands.pop_front();
                    s_valid         <= 1'b1;
                    s_op            <= in_flight.op;
                    s_x             <= in_flight.x;
                    s_y             <= in_flight.y;
                    s_carry_in      <= in_flight.carry_in;
                    s_rotate_amount <= in_flight.rotate_amount;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. The receiver stalls at random, except inside the burst window.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= burst || ($urandom_range(99) >= IDLE_PCT);
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result item with no prediction waiting: result=%h", m_result);
                    error_count++;
                end else begin
                    oldest_result = awaited_results.pop_front();
                    if (m_result !== oldest_result.result) begin
                        $error("result: expected %h, got %h", oldest_result.result, m_result);
                        error_count++;
                    end
                    if (m_product_high !== oldest_result.product_high) begin
                        $error("product_high: expected %h, got %h",
                               oldest_result.product_high, m_product_high);
                        error_count++;
                    end
                    if (m_carry_out !== oldest_result.carry_out) begin
                        $error("carry_out: expected %b, got %b",
                               oldest_result.carry_out, m_carry_out);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        logic [OP_W-1:0] op;
        // Directed items. They cover every count on a zero word, the length and population
        // count on an all-ones word, the zero counts on single-bit words, and the rotate
        // extremes. They also cover full carry and borrow chains, equal operands subtracted
        // with a borrow in, the largest product, and both ends of the unused opcode range.
        queue_operand(OP_LEN,      '0, '0, 1'b0, '0, 1'b0);
        queue_operand(OP_CLZ,      '0, '0, 1'b0, '0, 1'b0);
        queue_operand(OP_CTZ,      '0, '0, 1'b0, '0, 1'b0);
        queue_operand(OP_POPCOUNT, '0, '0, 1'b0, '0, 1'b0);
        queue_operand(OP_LEN,      '1, '1, 1'b1, '1, 1'b0);
        queue_operand(OP_CLZ,      64'h1, '0, 1'b0, '0, 1'b0);
        queue_operand(OP_CTZ,      64'h8000_0000_0000_0000, '0, 1'b0, '0, 1'b0);
        queue_operand(OP_POPCOUNT, '1, '0, 1'b0, '0, 1'b0);
        queue_operand(OP_ROTL,     64'h8000_0000_0000_0001, '0, 1'b0, '0, 1'b0);
        queue_operand(OP_ROTL,     64'h8000_0000_0000_0001, '0, 1'b0, '1, 1'b0);
        queue_operand(OP_ROTL,     64'h0123_4567_89ab_cdef, '0, 1'b0, 6'd32, 1'b0);
        queue_operand(OP_BITREV,   64'h0000_0000_0000_0001, '0, 1'b0, '0, 1'b0);
        queue_operand(OP_BITREV,   64'h0123_4567_89ab_cdef, '0, 1'b0, '0, 1'b0);
        queue_operand(OP_BYTEREV,  64'h0123_4567_89ab_cdef, '0, 1'b0, '0, 1'b0);
        queue_operand(OP_ADD,      '1, '1, 1'b1, '0, 1'b0);
        queue_operand(OP_ADD,      '1, '0, 1'b1, '0, 1'b0);
        queue_operand(OP_ADD,      '0, '0, 1'b0, '0, 1'b0);
        queue_operand(OP_SUB,      '0, '0, 1'b1, '0, 1'b0);
        queue_operand(OP_SUB,      64'h1234, 64'h1234, 1'b1, '0, 1'b0);
        queue_operand(OP_SUB,      '1, '1, 1'b0, '0, 1'b0);
        queue_operand(OP_SUB,      '0, '1, 1'b0, '0, 1'b0);
        queue_operand(OP_MUL,      '1, '1, 1'b0, '0, 1'b0);
        queue_operand(OP_MUL,      '0, '1, 1'b1, '1, 1'b0);
        queue_operand(OP_UNUSED_LO, '1, '1, 1'b1, '1, 1'b0);
        queue_operand(OP_UNUSED_HI, '1, '1, 1'b1, '1, 1'b0);

        // Random items. Most of them use the ten real opcodes. The sender pauses once
        // after the directed items and once partway through, until every outstanding
        // result has drained.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(9) == 0) begin
                op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            end else begin
                op = OP_W'($urandom_range(OP_MUL, OP_LEN));
            end
            queue_operand(op, shaped_word(), shaped_word(), 1'($urandom_range(1)),
                          ROT_W'($urandom_range(63)), (n == 0) || (n == 200));
        end

        // Sample at the falling edge so the clocked driver and monitor have settled.
        do begin
            @(negedge aclk);
        end while (pending_operands.size() != 0 || s_valid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
